/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ALIF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("neuron step unit: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ALIF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("neuron step unit: same-cycle check failed");

`endif

/* hw/rtl/alif_pkg.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF step unit package
// Types, constants, the microcode table and saturation helper shared by the
// modules of the neuron step unit.
// ---------------------------------------------------------------------------
package alif_pkg;

  // Number formats.
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DECAY_BITS    = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_DECAY   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_DECAY      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_THRESHOLD   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_SCALE      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_FLOOR    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_TICKS = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_CURRENT     = 8'd7;

  // Register reset values.
  localparam logic [15:0]        RST_MEMBRANE_DECAY   = 16'd59299;
  localparam logic [30:0]        RST_CURRENT_GAIN     = 31'd249;
  localparam logic [15:0]        RST_ADAPT_DECAY      = 16'd59299;
  localparam logic signed [31:0] RST_BASE_THRESHOLD   = 32'sd983040;
  localparam logic [30:0]        RST_ADAPT_SCALE      = 31'd65536;
  localparam logic signed [31:0] RST_VOLTAGE_FLOOR    = 32'sh8000_0000;
  localparam logic [15:0]        RST_REFRACTORY_TICKS = 16'd20;
  localparam logic signed [31:0] RST_BIAS_CURRENT     = 32'sd0;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0]        membrane_decay;
    logic [30:0]        current_gain;
    logic [15:0]        adapt_decay;
    logic signed [31:0] base_threshold;
    logic [30:0]        adapt_scale;
    logic signed [31:0] voltage_floor;
    logic [15:0]        refractory_ticks;
    logic signed [31:0] bias_current;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane;
    logic signed [31:0] threshold;
    logic [30:0]        adaptation;
    logic [15:0]        refractory_left;
  } res_t;

  // Multiplier operand pairs.
  typedef enum logic [1:0] {
    MUL_ADAPT,     // adapt_decay * adaptation level
    MUL_CURRENT,   // current_gain * held current
    MUL_THRESH,    // adapt_scale * new adaptation level
    MUL_MEMBRANE   // membrane_decay * voltage
  } mul_sel_e;

  // What the datapath does with the registered product.
  typedef enum logic [2:0] {
    POST_NONE,
    POST_ADAPT,
    POST_ACC,
    POST_THRESH,
    POST_FINAL
  } post_e;

  // Rounding shift applied to the product.
  typedef enum logic {
    RND_DECAY,
    RND_FRAC
  } rnd_e;

  // Jump conditions; the jump is taken while the condition holds.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_OUT_BUSY
  } cond_e;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ADAPT  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ACC    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_THRESH = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FINAL  = 3'd4;

  // One control word.
  typedef struct packed {
    mul_sel_e          mul_sel;
    post_e             post;
    rnd_e              rnd;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  // Sequencer inputs.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } status_t;

  // Sequencer outputs.
  typedef struct packed {
    ctrl_t ctrl;
    logic  go;
    logic  wait_in;
  } seq_t;

  // Microcode program for one neuron tick.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w.mul_sel = MUL_ADAPT;
    w.post    = POST_NONE;
    w.rnd     = RND_DECAY;
    w.cond    = COND_NONE;
    w.target  = STEP_IDLE;
    w.last    = 1'b0;
    case (step)
      // Wait for an item; the adaptation decay product runs meanwhile.
      STEP_IDLE: begin
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      // New adaptation level; start the input current product.
      STEP_ADAPT: begin
        w.mul_sel = MUL_CURRENT;
        w.post    = POST_ADAPT;
        w.rnd     = RND_DECAY;
      end
      // Current term plus spike input; start the threshold product.
      STEP_ACC: begin
        w.mul_sel = MUL_THRESH;
        w.post    = POST_ACC;
        w.rnd     = RND_FRAC;
      end
      // Adaptive threshold; start the membrane decay product.
      STEP_THRESH: begin
        w.mul_sel = MUL_MEMBRANE;
        w.post    = POST_THRESH;
        w.rnd     = RND_FRAC;
      end
      // Voltage, spike test and write-back; hold while the result slot is full.
      STEP_FINAL: begin
        w.mul_sel = MUL_MEMBRANE;
        w.post    = POST_FINAL;
        w.rnd     = RND_DECAY;
        w.cond    = COND_OUT_BUSY;
        w.target  = STEP_FINAL;
        w.last    = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/alif_ifs.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF step unit channels
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
interface alif_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] spike_input;
  logic signed [31:0] current_input;

  modport source (output valid, output spike_input, output current_input, input ready);
  modport sink   (input valid, input spike_input, input current_input, output ready);
endinterface

interface alif_out_if;
  logic               valid;
  logic               ready;
  logic               spike;
  logic signed [31:0] membrane;
  logic signed [31:0] threshold;
  logic [30:0]        adaptation;
  logic [15:0]        refractory_left;

  modport source (output valid, output spike, output membrane, output threshold,
                  output adaptation, output refractory_left, input ready);
  modport sink   (input valid, input spike, input membrane, input threshold,
                  input adaptation, input refractory_left, output ready);
endinterface

interface alif_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [alif_pkg::CFG_IDX_W-1:0]   index;
  logic [alif_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/alif_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF configuration registers
// Holds the eight neuron parameters; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
module alif_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [alif_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [alif_pkg::CFG_DATA_W-1:0] data_i,
  output alif_pkg::cfg_t                  cfg_o
);

  alif_pkg::cfg_t cfg_q;

  // Register write, only the low bits of each field are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.membrane_decay   <= alif_pkg::RST_MEMBRANE_DECAY;
      cfg_q.current_gain     <= alif_pkg::RST_CURRENT_GAIN;
      cfg_q.adapt_decay      <= alif_pkg::RST_ADAPT_DECAY;
      cfg_q.base_threshold   <= alif_pkg::RST_BASE_THRESHOLD;
      cfg_q.adapt_scale      <= alif_pkg::RST_ADAPT_SCALE;
      cfg_q.voltage_floor    <= alif_pkg::RST_VOLTAGE_FLOOR;
      cfg_q.refractory_ticks <= alif_pkg::RST_REFRACTORY_TICKS;
      cfg_q.bias_current     <= alif_pkg::RST_BIAS_CURRENT;
    end else if (we_i) begin
      unique case (idx_i)
        alif_pkg::REG_MEMBRANE_DECAY:   cfg_q.membrane_decay   <= data_i[15:0];
        alif_pkg::REG_CURRENT_GAIN:     cfg_q.current_gain     <= data_i[30:0];
        alif_pkg::REG_ADAPT_DECAY:      cfg_q.adapt_decay      <= data_i[15:0];
        alif_pkg::REG_BASE_THRESHOLD:   cfg_q.base_threshold   <= $signed(data_i[31:0]);
        alif_pkg::REG_ADAPT_SCALE:      cfg_q.adapt_scale      <= data_i[30:0];
        alif_pkg::REG_VOLTAGE_FLOOR:    cfg_q.voltage_floor    <= $signed(data_i[31:0]);
        alif_pkg::REG_REFRACTORY_TICKS: cfg_q.refractory_ticks <= data_i[15:0];
        alif_pkg::REG_BIAS_CURRENT:     cfg_q.bias_current     <= $signed(data_i[31:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/alif_sequencer.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF microcode sequencer
// Step counter over the control-word table with conditional jumps.
// ---------------------------------------------------------------------------
module alif_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alif_pkg::status_t status_i,
  output alif_pkg::seq_t    seq_o
);

  logic [alif_pkg::STEP_W-1:0] step_q, step_d;
  alif_pkg::ctrl_t             ctrl;
  logic                        jump;

  // Fetch the control word of the current step.
  assign ctrl = alif_pkg::ucode(step_q);

  // Evaluate the jump condition.
  always_comb begin
    unique case (ctrl.cond)
      alif_pkg::COND_NO_INPUT: jump = !status_i.in_valid;
      alif_pkg::COND_OUT_BUSY: jump = status_i.out_busy;
      default:                 jump = 1'b0;
    endcase
  end

  // Next step: jump target, back to idle after the last step, or sequential.
  always_comb begin
    if (jump) begin
      step_d = ctrl.target;
    end else if (ctrl.last) begin
      step_d = alif_pkg::STEP_IDLE;
    end else begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= alif_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign seq_o.ctrl    = ctrl;
  assign seq_o.go      = !jump;
  assign seq_o.wait_in = (ctrl.cond == alif_pkg::COND_NO_INPUT);

endmodule

/* hw/rtl/alif_datapath.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF datapath
// Shared multiplier with a registered product, rounding shift, saturating
// adders and the neuron state, driven by one control word per cycle.
// ---------------------------------------------------------------------------
module alif_datapath #(
  parameter int unsigned FRAC_BITS = alif_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alif_pkg::ctrl_t    ctrl_i,
  input  logic               go_i,
  input  logic               accept_i,
  input  logic signed [31:0] spike_input_i,
  input  logic signed [31:0] current_input_i,
  input  alif_pkg::cfg_t     cfg_i,
  output alif_pkg::res_t     res_o
);

  localparam logic signed [63:0] HALF_FRAC  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_DECAY = 64'sd1 <<< (alif_pkg::DECAY_BITS - 1);
  localparam logic signed [63:0] ONE_FRAC   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] MAX_ADAPT  = 64'sh0000_0000_7FFF_FFFF;

  // Neuron state.
  logic signed [31:0] voltage_q;
  logic [30:0]        adapt_q;
  logic signed [31:0] held_q;
  logic               last_spike_q;
  logic [15:0]        refr_q;

  // Working registers.
  logic signed [31:0] spike_in_q, cur_in_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] thr_q, thr_d;
  alif_pkg::res_t     res_q, res_d;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rnd_sum, rnd_val;
  logic signed [63:0] a_sum;
  logic [30:0]        adapt_d;
  logic signed [31:0] v_sat, v_flr, v_out, held_d;
  logic [15:0]        refr_dec, refr_d;
  logic               fire;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl_i.mul_sel)
      alif_pkg::MUL_ADAPT: begin
        mul_a = $signed({1'b0, adapt_q});
        mul_b = $signed({16'd0, cfg_i.adapt_decay});
      end
      alif_pkg::MUL_CURRENT: begin
        mul_a = held_q;
        mul_b = $signed({1'b0, cfg_i.current_gain});
      end
      alif_pkg::MUL_THRESH: begin
        mul_a = $signed({1'b0, adapt_q});
        mul_b = $signed({1'b0, cfg_i.adapt_scale});
      end
      default: begin
        mul_a = voltage_q;
        mul_b = $signed({16'd0, cfg_i.membrane_decay});
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Round to nearest, halves up, then shift out the fraction bits.
  always_comb begin
    if (ctrl_i.rnd == alif_pkg::RND_FRAC) begin
      rnd_sum = prod_q + HALF_FRAC;
      rnd_val = rnd_sum >>> FRAC_BITS;
    end else begin
      rnd_sum = prod_q + HALF_DECAY;
      rnd_val = rnd_sum >>> alif_pkg::DECAY_BITS;
    end
  end

  // Adaptation: decayed level plus one when the last tick spiked, kept in range.
  always_comb begin
    a_sum = rnd_val + (last_spike_q ? ONE_FRAC : 64'sd0);
    if (a_sum > MAX_ADAPT) begin
      adapt_d = 31'h7FFF_FFFF;
    end else if (a_sum < 64'sd0) begin
      adapt_d = 31'd0;
    end else begin
      adapt_d = a_sum[30:0];
    end
  end

  // Current term plus spike input, and the adaptive threshold.
  assign acc_d = rnd_val + 64'(spike_in_q);
  assign thr_d = alif_pkg::sat32(64'(cfg_i.base_threshold) + rnd_val);

  // Final voltage, floor, spike test and reset subtraction.
  always_comb begin
    v_sat    = alif_pkg::sat32(acc_q + rnd_val);
    v_flr    = (v_sat < cfg_i.voltage_floor) ? cfg_i.voltage_floor : v_sat;
    refr_dec = (refr_q != 16'd0) ? (refr_q - 16'd1) : refr_q;
    fire     = (v_flr >= thr_q) && (refr_dec == 16'd0);
    v_out    = fire ? alif_pkg::sat32(64'(v_flr) - 64'(cfg_i.base_threshold)) : v_flr;
    refr_d   = fire ? cfg_i.refractory_ticks : refr_dec;
    held_d   = alif_pkg::sat32(64'(cur_in_q) + 64'(cfg_i.bias_current));
  end

  always_comb begin
    res_d.spike           = fire;
    res_d.membrane        = v_out;
    res_d.threshold       = thr_q;
    res_d.adaptation      = adapt_q;
    res_d.refractory_left = refr_d;
  end

  // Neuron state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voltage_q    <= 32'sd0;
      adapt_q      <= 31'd0;
      held_q       <= 32'sd0;
      last_spike_q <= 1'b0;
      refr_q       <= 16'd0;
    end else if (go_i) begin
      case (ctrl_i.post)
        alif_pkg::POST_ADAPT: begin
          adapt_q <= adapt_d;
        end
        alif_pkg::POST_FINAL: begin
          voltage_q    <= v_out;
          held_q       <= held_d;
          last_spike_q <= fire;
          refr_q       <= refr_d;
        end
        default: begin
        end
      endcase
    end
  end

  // Product, operands and intermediate results.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept_i) begin
      spike_in_q <= spike_input_i;
      cur_in_q   <= current_input_i;
    end
    if (go_i && (ctrl_i.post == alif_pkg::POST_ACC)) begin
      acc_q <= acc_d;
    end
    if (go_i && (ctrl_i.post == alif_pkg::POST_THRESH)) begin
      thr_q <= thr_d;
    end
    if (go_i && (ctrl_i.post == alif_pkg::POST_FINAL)) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/adaptive_lif_neuron_step_unit.sv */
// ---------------------------------------------------------------------------
// Adaptive LIF neuron step unit
// One input item is one simulation tick of an adaptive leaky integrate-and-
// fire neuron; each tick returns one result item.
//
//   Channel   Port    Dir   Carries
//   --------  ------  ----  -------------------------------------------------
//   input     in_i    in    spike_input, current_input
//   result    out_o   out   spike, membrane, threshold, adaptation,
//                           refractory_left
//   config    cfg_i   in    index, data (register write)
//
// An item passes through the accept cycle, which starts the first of four
// products on the shared multiplier, and then four more microcode steps; the
// last step forms the voltage, the spike test and the write-back.
// The next item is accepted in the cycle after the last step. A result waits in
// the output register and stalls the block only in its last step while full.
// Reset brings the neuron state to zero and the registers to their defaults.
// ---------------------------------------------------------------------------
module adaptive_lif_neuron_step_unit #(
  parameter int unsigned FRAC_BITS = alif_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  alif_in_if.sink      in_i,
  alif_out_if.source   out_o,
  alif_cfg_if.sink     cfg_i
);

  alif_pkg::cfg_t    cfg;
  alif_pkg::status_t status;
  alif_pkg::seq_t    seq;
  alif_pkg::res_t    res;
  logic              in_accept;
  logic              final_go;
  logic              out_valid_q;

  // Configuration registers, always ready.
  assign cfg_i.ready = 1'b1;

  alif_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg)
  );

  // Sequencer.
  assign status.in_valid = in_i.valid;
  assign status.out_busy = out_valid_q && !out_o.ready;

  alif_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .seq_o    (seq)
  );

  assign in_i.ready = seq.wait_in;
  assign in_accept  = in_i.valid && in_i.ready;
  assign final_go   = seq.go && (seq.ctrl.post == alif_pkg::POST_FINAL);

  // Datapath.
  alif_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (seq.ctrl),
    .go_i            (seq.go),
    .accept_i        (in_accept),
    .spike_input_i   (in_i.spike_input),
    .current_input_i (in_i.current_input),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  // Result slot valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (final_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.spike           = res.spike;
  assign out_o.membrane        = res.membrane;
  assign out_o.threshold       = res.threshold;
  assign out_o.adaptation      = res.adaptation;
  assign out_o.refractory_left = res.refractory_left;

  // Checks on the program flow.
`include "assert_macros.svh"

  `ALIF_ASSERT_NEXT(a_accept_to_adapt, in_accept, seq.ctrl.post == alif_pkg::POST_ADAPT)
  `ALIF_ASSERT_NEXT(a_no_back_to_back, in_accept, !in_accept)
  `ALIF_ASSERT_NEXT(a_final_fills_slot, final_go, out_valid_q)
  `ALIF_ASSERT_SAME(a_slot_from_final, $rose(out_valid_q), $past(final_go))

endmodule

/* sim/testbench.sv */
// -----------------------------------------------------------------------------
// Adaptive LIF neuron step unit testbench
// Sends neuron ticks through the input channel and checks every result item
// against a cycle-free model of the neuron kept in this file, or against a
// result typed into the table. A short table of directed ticks and register
// writes comes first. Random phases follow with changing settings and idling
// on both channels. A run of steady firing builds up the adaptation, and a
// last phase checks a saturated threshold and the longest refractory period.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC            = alif_pkg::FRAC_BITS_DEF;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam longint      CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned TICKS_PER_PHASE = 220;
  localparam int unsigned CLIMB_TICKS     = 200;
  localparam int unsigned SPIKE_SPAN      = 1 << 20;
  localparam int unsigned CURRENT_SPAN    = 1 << 22;
  localparam longint      S32_MAX         = 64'sd2147483647;
  localparam longint      S32_MIN         = -64'sd2147483648;
  localparam logic [31:0] WORD_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN        = 32'h8000_0000;
  localparam logic [31:0] WORD_ONES       = 32'hFFFF_FFFF;
  localparam logic [alif_pkg::CFG_IDX_W-1:0] REG_NONE = 8'hFF;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // One row of the directed table: a tick or a register write.
  typedef struct {
    row_kind_e                      kind;
    logic [alif_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    a;
    logic [31:0]                    b;
    bit                             known;
    alif_pkg::res_t                 want;
  } stim_row_t;

  // A tick's result when it is typed into the table.
  typedef struct {
    bit             known;
    alif_pkg::res_t res;
  } typed_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  alif_in_if  in_ch ();
  alif_out_if res_ch ();
  alif_cfg_if cfg_ch ();

  adaptive_lif_neuron_step_unit #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (res_ch),
    .cfg_i (cfg_ch)
  );

  // Settings copy, in the same units as the registers.
  longint set_membrane_decay   = longint'(alif_pkg::RST_MEMBRANE_DECAY);
  longint set_current_gain     = longint'(alif_pkg::RST_CURRENT_GAIN);
  longint set_adapt_decay      = longint'(alif_pkg::RST_ADAPT_DECAY);
  longint set_base_threshold   = longint'(alif_pkg::RST_BASE_THRESHOLD);
  longint set_adapt_scale      = longint'(alif_pkg::RST_ADAPT_SCALE);
  longint set_voltage_floor    = longint'(alif_pkg::RST_VOLTAGE_FLOOR);
  longint set_refractory_ticks = longint'(alif_pkg::RST_REFRACTORY_TICKS);
  longint set_bias_current     = longint'(alif_pkg::RST_BIAS_CURRENT);

  // Neuron state as it should be after the last accepted tick.
  longint nrn_voltage      = 0;
  longint nrn_adapt        = 0;
  longint nrn_held_current = 0;
  bit     nrn_fired        = 1'b0;
  longint nrn_refractory   = 0;

  alif_pkg::res_t neuron_outputs_due[$];
  typed_result_t  typed_results[$];
  stim_row_t      directed_rows[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  longint      cycle_count    = 0;

  // Clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adaptive_lif_neuron_step_unit verification failed");
      $finish;
    end
  end

  // Result channel back-pressure.
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Product with rounding to nearest, halves upward, then the shift.
  function automatic longint round_half_up(longint p, int unsigned s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > S32_MAX) begin
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      return S32_MIN;
    end
    return v;
  endfunction

  // Advance the neuron by one tick and return what the block should report.
  function automatic alif_pkg::res_t advance_neuron(logic signed [31:0] spike_in,
                                                    logic signed [31:0] current_in);
    longint         v;
    longint         a;
    longint         thr;
    bit             fire;
    alif_pkg::res_t r;
    if (nrn_refractory > 0) begin
      nrn_refractory = nrn_refractory - 1;
    end

    // Membrane: stored current, this tick's spikes and the leaky old voltage.
    v = round_half_up(set_current_gain * nrn_held_current, FRAC) + longint'(spike_in)
        + round_half_up(set_membrane_decay * nrn_voltage, alif_pkg::DECAY_BITS);
    v = clamp_s32(v);
    if (v < set_voltage_floor) begin
      v = set_voltage_floor;
    end

    // Adaptation decays and picks up the previous tick's spike.
    a = round_half_up(set_adapt_decay * nrn_adapt, alif_pkg::DECAY_BITS);
    if (nrn_fired) begin
      a = a + (longint'(1) <<< FRAC);
    end
    if (a > S32_MAX) begin
      a = S32_MAX;
    end
    if (a < 0) begin
      a = 0;
    end
    nrn_adapt = a;

    thr  = clamp_s32(set_base_threshold + round_half_up(set_adapt_scale * a, FRAC));
    fire = (v >= thr) && (nrn_refractory == 0);
    if (fire) begin
      v              = clamp_s32(v - set_base_threshold);
      nrn_refractory = set_refractory_ticks;
    end
    nrn_voltage      = v;
    nrn_fired        = fire;
    nrn_held_current = clamp_s32(longint'(current_in) + set_bias_current);

    r.spike           = fire;
    r.membrane        = v[31:0];
    r.threshold       = thr[31:0];
    r.adaptation      = a[30:0];
    r.refractory_left = nrn_refractory[15:0];
    return r;
  endfunction

  // Register write into the settings copy; only the low bits of each count.
  function automatic void apply_register(logic [alif_pkg::CFG_IDX_W-1:0] idx,
                                         logic [31:0] data);
    case (idx)
      alif_pkg::REG_MEMBRANE_DECAY:   set_membrane_decay   = longint'(data[15:0]);
      alif_pkg::REG_CURRENT_GAIN:     set_current_gain     = longint'(data[30:0]);
      alif_pkg::REG_ADAPT_DECAY:      set_adapt_decay      = longint'(data[15:0]);
      alif_pkg::REG_BASE_THRESHOLD:   set_base_threshold   = longint'($signed(data));
      alif_pkg::REG_ADAPT_SCALE:      set_adapt_scale      = longint'(data[30:0]);
      alif_pkg::REG_VOLTAGE_FLOOR:    set_voltage_floor    = longint'($signed(data));
      alif_pkg::REG_REFRACTORY_TICKS: set_refractory_ticks = longint'(data[15:0]);
      alif_pkg::REG_BIAS_CURRENT:     set_bias_current     = longint'($signed(data));
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // Every accepted register write updates the settings copy.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      apply_register(cfg_ch.index, cfg_ch.data);
    end
  end

  // Every accepted tick queues its expected result.
  always @(posedge clk_i) begin : accept_tick
    typed_result_t  typed;
    alif_pkg::res_t predicted;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      typed     = typed_results.pop_front();
      predicted = advance_neuron(in_ch.spike_input, in_ch.current_input);
      neuron_outputs_due.push_back(typed.known ? typed.res : predicted);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_result
    alif_pkg::res_t got;
    alif_pkg::res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.spike           = res_ch.spike;
      got.membrane        = res_ch.membrane;
      got.threshold       = res_ch.threshold;
      got.adaptation      = res_ch.adaptation;
      got.refractory_left = res_ch.refractory_left;
      if (neuron_outputs_due.size() == 0) begin
        flag_mismatch("result with none due, membrane", longint'(got.membrane), 0);
      end else begin
        want = neuron_outputs_due.pop_front();
        if (got.spike !== want.spike) begin
          flag_mismatch("spike", longint'(got.spike), longint'(want.spike));
        end
        if (got.membrane !== want.membrane) begin
          flag_mismatch("membrane", longint'(got.membrane), longint'(want.membrane));
        end
        if (got.threshold !== want.threshold) begin
          flag_mismatch("threshold", longint'(got.threshold), longint'(want.threshold));
        end
        if (got.adaptation !== want.adaptation) begin
          flag_mismatch("adaptation", longint'(got.adaptation), longint'(want.adaptation));
        end
        if (got.refractory_left !== want.refractory_left) begin
          flag_mismatch("refractory_left", longint'(got.refractory_left),
                        longint'(want.refractory_left));
        end
      end
      results_seen = results_seen + 1;
    end
  end

  // Offer one tick, wait for it to be taken, then maybe leave the channel idle.
  task automatic send_tick(logic [31:0] spike_in, logic [31:0] current_in,
                           bit known, alif_pkg::res_t want);
    typed_results.push_back('{known, want});
    in_ch.valid         <= 1'b1;
    in_ch.spike_input   <= spike_in;
    in_ch.current_input <= current_in;
    do @(posedge clk_i); while (!in_ch.ready);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Register write; the caller lowers valid after the last one.
  task automatic write_reg(logic [alif_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Stop offering, wait for every due result, then give the block time to go idle.
  task automatic drain_results();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (neuron_outputs_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic add_tick(logic [31:0] spike_in, logic [31:0] current_in);
    directed_rows.push_back('{ROW_TICK, REG_NONE, spike_in, current_in, 1'b0, '0});
  endtask

  task automatic add_known_tick(logic [31:0] spike_in, logic [31:0] current_in,
                                alif_pkg::res_t want);
    directed_rows.push_back('{ROW_TICK, REG_NONE, spike_in, current_in, 1'b1, want});
  endtask

  task automatic add_write(logic [alif_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    directed_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
  endtask

  // Setting for one register: an extreme now and then, else a working value.
  // Narrow registers get junk in the unused high bits.
  function automatic logic [31:0] pick_setting(logic [alif_pkg::CFG_IDX_W-1:0] idx);
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(7);
    case (idx)
      alif_pkg::REG_MEMBRANE_DECAY: begin
        v = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 : $urandom_range(40000, 65535);
        v = v | ($urandom() & 32'hFFFF_0000);
      end
      alif_pkg::REG_CURRENT_GAIN: begin
        v = (sel == 0) ? 32'd0 : (sel == 1) ? WORD_MAX : $urandom_range(0, 1 << 18);
        v = v | ($urandom() & WORD_MIN);
      end
      alif_pkg::REG_ADAPT_DECAY: begin
        v = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 : $urandom_range(0, 65535);
        v = v | ($urandom() & 32'hFFFF_0000);
      end
      alif_pkg::REG_BASE_THRESHOLD: begin
        v = (sel == 0) ? WORD_MIN : (sel == 1) ? WORD_MAX : $urandom_range(1 << 14, 1 << 22);
      end
      alif_pkg::REG_ADAPT_SCALE: begin
        v = (sel == 0) ? 32'd0 : (sel == 1) ? WORD_MAX : $urandom_range(0, 1 << 18);
        v = v | ($urandom() & WORD_MIN);
      end
      alif_pkg::REG_VOLTAGE_FLOOR: begin
        v = (sel == 0) ? WORD_MIN : (sel == 1) ? WORD_MAX : -$urandom_range(0, 1 << 24);
      end
      alif_pkg::REG_REFRACTORY_TICKS: begin
        // Long refractory periods would silence the rest of the run.
        v = (sel == 0) ? 32'd0 : $urandom_range(0, 6);
        v = v | ($urandom() & 32'hFFFF_0000);
      end
      alif_pkg::REG_BIAS_CURRENT: begin
        v = (sel == 0) ? WORD_MIN : (sel == 1) ? WORD_MAX
            : $urandom_range(0, 1 << 19) - (1 << 18);
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  // Input value: mostly near the working range, sometimes extreme or raw.
  function automatic logic [31:0] pick_input(int unsigned span);
    int unsigned sel;
    sel = $urandom_range(15);
    case (sel)
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return 32'd0;
      3, 4:    return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  initial begin : stimulus
    in_ch.valid         = 1'b0;
    in_ch.spike_input   = '0;
    in_ch.current_input = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    res_ch.ready        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a quiet first tick, then a full-scale spike that fires.
    add_known_tick(32'd0, 32'd0, '{spike: 1'b0, membrane: 32'sd0,
                   threshold: 32'sd983040, adaptation: 31'd0, refractory_left: 16'd0});
    add_known_tick(WORD_MAX, 32'd0, '{spike: 1'b1, membrane: 32'sd2146500607,
                   threshold: 32'sd983040, adaptation: 31'd0, refractory_left: 16'd20});
    add_tick(WORD_MIN, WORD_MAX);
    add_tick(32'd0, WORD_MIN);
    add_tick(32'd1, WORD_ONES);
    add_tick(32'h5555_5555, 32'hAAAA_AAAA);
    add_tick(32'hAAAA_AAAA, 32'h5555_5555);

    // Largest gains, membrane decay 0, floor above threshold, no refractory period.
    add_write(alif_pkg::REG_MEMBRANE_DECAY, 32'hFFFF_0000);
    add_write(alif_pkg::REG_CURRENT_GAIN, WORD_ONES);
    add_write(alif_pkg::REG_ADAPT_DECAY, 32'hABCD_FFFF);
    add_write(alif_pkg::REG_BASE_THRESHOLD, 32'h0001_0000);
    add_write(alif_pkg::REG_ADAPT_SCALE, WORD_ONES);
    add_write(alif_pkg::REG_VOLTAGE_FLOOR, 32'h0010_0000);
    add_write(alif_pkg::REG_REFRACTORY_TICKS, 32'h1234_0000);
    add_write(alif_pkg::REG_BIAS_CURRENT, WORD_MIN);
    add_write(REG_NONE, 32'hDEAD_BEEF);
    add_tick(32'd0, 32'd0);
    add_tick(WORD_MIN, WORD_MIN);
    add_tick(WORD_MAX, WORD_MAX);
    add_tick(32'd0, 32'd0);
    add_tick(WORD_ONES, 32'd1);
    add_tick(32'd0, 32'd0);

    // Most negative base threshold: the reset step pushes the voltage up.
    add_write(alif_pkg::REG_BASE_THRESHOLD, WORD_MIN);
    add_write(alif_pkg::REG_VOLTAGE_FLOOR, WORD_MIN);
    add_write(alif_pkg::REG_REFRACTORY_TICKS, 32'hFFFF_0003);
    add_write(alif_pkg::REG_BIAS_CURRENT, WORD_MAX);
    add_write(alif_pkg::REG_MEMBRANE_DECAY, 32'h0000_FFFF);
    add_write(alif_pkg::REG_CURRENT_GAIN, 32'd0);
    add_write(alif_pkg::REG_ADAPT_DECAY, 32'd0);
    add_write(alif_pkg::REG_ADAPT_SCALE, 32'd0);
    add_tick(WORD_MAX, WORD_MAX);
    add_tick(WORD_MIN, WORD_MIN);
    add_tick(32'd0, 32'd0);
    add_tick(WORD_MAX, 32'd0);
    add_tick(32'd0, 32'd0);

    // Largest base threshold: only the largest voltage can reach it.
    add_write(alif_pkg::REG_BASE_THRESHOLD, WORD_MAX);
    add_tick(WORD_MAX, 32'd0);
    add_tick(WORD_MAX, 32'd0);

    set_idling(34, 34);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_WRITE) begin
          drain_results();
        end
        write_reg(directed_rows[i].index, directed_rows[i].a);
      end else begin
        if (i > 0 && directed_rows[i-1].kind == ROW_WRITE) begin
          cfg_ch.valid <= 1'b0;
        end
        send_tick(directed_rows[i].a, directed_rows[i].b, directed_rows[i].known,
                  directed_rows[i].want);
      end
    end
    drain_results();

    // Random phases: new settings each time, idling pattern rotating.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int unsigned r = alif_pkg::REG_MEMBRANE_DECAY;
           r <= alif_pkg::REG_BIAS_CURRENT; r++) begin
        write_reg(r[alif_pkg::CFG_IDX_W-1:0], pick_setting(r[alif_pkg::CFG_IDX_W-1:0]));
      end
      if ($urandom_range(3) == 0) begin
        write_reg(REG_NONE, $urandom());
      end
      cfg_ch.valid <= 1'b0;
      case (phase % 4)
        0:       set_idling(0, 0);
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        default: set_idling(34, 34);
      endcase
      for (int unsigned n = 0; n < TICKS_PER_PHASE; n++) begin
        send_tick(pick_input(SPIKE_SPAN), pick_input(CURRENT_SPAN), 1'b0, '0);
      end
      drain_results();
    end

    // Fire on every tick with the slowest adaptation decay, so that the
    // adaptation builds up to a large level.
    write_reg(alif_pkg::REG_ADAPT_DECAY, 32'd65535);
    write_reg(alif_pkg::REG_BASE_THRESHOLD, WORD_MIN);
    write_reg(alif_pkg::REG_ADAPT_SCALE, 32'd0);
    write_reg(alif_pkg::REG_REFRACTORY_TICKS, 32'd0);
    write_reg(alif_pkg::REG_VOLTAGE_FLOOR, WORD_MIN);
    cfg_ch.valid <= 1'b0;
    set_idling(0, 0);
    for (int unsigned n = 0; n < CLIMB_TICKS; n++) begin
      send_tick(pick_input(SPIKE_SPAN), pick_input(CURRENT_SPAN), 1'b0, '0);
    end
    drain_results();

    // The built-up adaptation times the largest scale saturates the threshold;
    // full-scale spikes meet it and may load the longest refractory period.
    write_reg(alif_pkg::REG_ADAPT_SCALE, WORD_MAX);
    write_reg(alif_pkg::REG_REFRACTORY_TICKS, 32'h0000_FFFF);
    cfg_ch.valid <= 1'b0;
    set_idling(34, 34);
    for (int unsigned n = 0; n < 4; n++) begin
      send_tick(WORD_MAX, 32'd0, 1'b0, '0);
    end
    for (int unsigned n = 0; n < 12; n++) begin
      send_tick(pick_input(SPIKE_SPAN), pick_input(CURRENT_SPAN), 1'b0, '0);
    end
    drain_results();

    if (mismatches == 0) begin
      $display("adaptive_lif_neuron_step_unit verification clean");
    end else begin
      $display("adaptive_lif_neuron_step_unit verification failed");
    end
    $finish;
  end

endmodule
